// File: rtl/pugm_pkg.sv
package pugm_pkg;

   // Code point width kept in the map; the map has 2**CODE_BITS entries.
   localparam int CODE_BITS = 16;
   localparam int MAP_DEPTH = 2 ** CODE_BITS;

   localparam int GLYPH_W  = 16;
   localparam int HDR_W    = 16;
   localparam int BPG_W    = 13;
   localparam int OFFSET_W = 29;
   localparam int PROD_W   = GLYPH_W + BPG_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_PRESENT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_COUNT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SIZE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_GLYPH = 2'd3;

   localparam logic [HDR_W-1:0] HEADER_SIZE_RST     = 16'd32;
   localparam logic [BPG_W-1:0] BYTES_PER_GLYPH_RST = 13'd16;

   localparam logic ACTION_FEED   = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   localparam logic OP_KIND_WRITE  = 1'b0;
   localparam logic OP_KIND_LOOKUP = 1'b1;

   localparam logic [7:0] BYTE_GLYPH_END = 8'hFF;

   // Queue between decoder and map
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 3;

   // Result queue
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = 2;
   localparam int RQ_CNT_W = 3;

   typedef struct packed {
      logic                 kind;
      logic [CODE_BITS-1:0] addr;
      logic [GLYPH_W-1:0]   data;
   } op_type;

   typedef struct packed {
      logic               table_present;
      logic [GLYPH_W-1:0] glyph_count;
      logic [HDR_W-1:0]   header_size;
      logic [BPG_W-1:0]   bytes_per_glyph;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } stat_type;

endpackage

// File: rtl/pugm_front.sv
module pugm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_action,
   input  logic [7:0]                req_table_byte,
   input  logic [15:0]               req_codepoint,
   input  pugm_pkg::stat_type        stat,
   output logic                      op_valid,
   output pugm_pkg::op_type          op,
   input  logic                      op_pop
);
   import pugm_pkg::*;

   logic [GLYPH_W-1:0]   glyph_counter_ff, glyph_counter_in;
   logic [1:0]           bytes_pending_ff, bytes_pending_in;
   logic [CODE_BITS-1:0] partial_code_ff, partial_code_in;

   op_type               oq_mem_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]  oq_wr_ff, oq_wr_in;
   logic [OQ_PTR_W-1:0]  oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0]  oq_count_ff, oq_count_in;

   logic   accept;
   logic   enq;
   op_type enq_op;

   assign full   = (oq_count_ff == OQ_CNT_W'(OQ_DEPTH)) || stat.clearing;
   assign accept = push && !full;

   // UTF-8 lead / continuation decode, 0xFF glyph breaks and lookups
   always_comb begin
      glyph_counter_in = glyph_counter_ff;
      bytes_pending_in = bytes_pending_ff;
      partial_code_in  = partial_code_ff;
      enq              = 1'b0;
      enq_op.kind      = OP_KIND_WRITE;
      enq_op.addr      = '0;
      enq_op.data      = glyph_counter_ff;
      if (accept) begin
         if (req_action == ACTION_LOOKUP) begin
            enq         = 1'b1;
            enq_op.kind = OP_KIND_LOOKUP;
            enq_op.addr = req_codepoint[CODE_BITS-1:0];
         end else if (bytes_pending_ff != 2'd0) begin
            partial_code_in  = {partial_code_ff[CODE_BITS-7:0], req_table_byte[5:0]};
            bytes_pending_in = bytes_pending_ff - 2'd1;
            if (bytes_pending_ff == 2'd1) begin
               enq         = 1'b1;
               enq_op.addr = partial_code_in;
            end
         end else if (req_table_byte == BYTE_GLYPH_END) begin
            glyph_counter_in = glyph_counter_ff + GLYPH_W'(1);
         end else if (!req_table_byte[7]) begin
            enq         = 1'b1;
            enq_op.addr = CODE_BITS'(req_table_byte);
         end else if (!req_table_byte[5]) begin
            partial_code_in  = CODE_BITS'(req_table_byte[4:0]);
            bytes_pending_in = 2'd1;
         end else if (!req_table_byte[4]) begin
            partial_code_in  = CODE_BITS'(req_table_byte[3:0]);
            bytes_pending_in = 2'd2;
         end else if (!req_table_byte[3]) begin
            partial_code_in  = CODE_BITS'(req_table_byte[2:0]);
            bytes_pending_in = 2'd3;
         end else begin
            // invalid lead maps code point 0
            enq = 1'b1;
         end
      end
   end

   assign op_valid = (oq_count_ff != '0);
   assign op       = oq_mem_ff[oq_rd_ff];

   always_comb begin
      oq_wr_in    = oq_wr_ff + OQ_PTR_W'(enq);
      oq_rd_in    = oq_rd_ff + OQ_PTR_W'(op_pop);
      oq_count_in = oq_count_ff + OQ_CNT_W'(enq) - OQ_CNT_W'(op_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_counter_ff <= '0;
         bytes_pending_ff <= '0;
         partial_code_ff  <= '0;
         oq_wr_ff         <= '0;
         oq_rd_ff         <= '0;
         oq_count_ff      <= '0;
      end else begin
         glyph_counter_ff <= glyph_counter_in;
         bytes_pending_ff <= bytes_pending_in;
         partial_code_ff  <= partial_code_in;
         oq_wr_ff         <= oq_wr_in;
         oq_rd_ff         <= oq_rd_in;
         oq_count_ff      <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         oq_mem_ff[oq_wr_ff] <= enq_op;
      end
   end

   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_count_ff <= OQ_CNT_W'(OQ_DEPTH))
      else $error("op queue overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      op_pop |-> op_valid)
      else $error("op popped from empty queue");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !accept)
      else $error("request accepted during map clear");

endmodule

// File: rtl/pugm_back.sv
module pugm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  pugm_pkg::cfg_type                 cfg,
   output pugm_pkg::stat_type                stat,
   input  logic                              op_valid,
   input  pugm_pkg::op_type                  op,
   output logic                              op_pop,
   output logic                              empty,
   input  logic                              pop,
   output logic [pugm_pkg::GLYPH_W-1:0]      rsp_glyph_index,
   output logic [pugm_pkg::OFFSET_W-1:0]     rsp_glyph_offset
);
   import pugm_pkg::*;

   logic [GLYPH_W-1:0]   map_mem [MAP_DEPTH];

   logic                 clr_ff, clr_in;
   logic [CODE_BITS-1:0] clr_addr_ff, clr_addr_in;

   // stage 1: map read
   logic                 s1_valid_ff;
   logic [GLYPH_W-1:0]   s1_rd_ff;
   logic [CODE_BITS-1:0] s1_code_ff;
   // stage 2: clamp and multiply
   logic                 s2_valid_ff;
   logic [GLYPH_W-1:0]   s2_idx_ff, s2_idx_in;
   logic [PROD_W-1:0]    s2_prod_ff;
   logic [GLYPH_W-1:0]   mapped;

   logic [GLYPH_W-1:0]   rq_idx_ff [RQ_DEPTH];
   logic [OFFSET_W-1:0]  rq_off_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]  rq_wr_ff, rq_rd_ff;
   logic [RQ_CNT_W-1:0]  rq_count_ff, rq_count_in;
   logic [RQ_CNT_W-1:0]  committed;
   logic                 rq_pop;
   logic                 lookup_go;
   logic                 write_go;

   assign stat.clearing = clr_ff;

   // hold off every op, writes too, unless a result slot is left for a lookup
   assign committed = rq_count_ff + RQ_CNT_W'(s1_valid_ff) + RQ_CNT_W'(s2_valid_ff);
   assign op_pop    = op_valid && !clr_ff && (committed < RQ_CNT_W'(RQ_DEPTH));
   assign lookup_go = op_pop && (op.kind == OP_KIND_LOOKUP);
   assign write_go  = op_pop && (op.kind == OP_KIND_WRITE);

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + CODE_BITS'(1);
         if (clr_addr_ff == CODE_BITS'(MAP_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         map_mem[clr_addr_ff] <= '0;
      end else if (write_go) begin
         map_mem[op.addr] <= op.data;
      end
   end

   always_ff @(posedge clock) begin
      s1_rd_ff   <= map_mem[op.addr];
      s1_code_ff <= op.addr;
   end

   always_comb begin
      mapped    = cfg.table_present ? s1_rd_ff : GLYPH_W'(s1_code_ff);
      s2_idx_in = (mapped != '0 && mapped < cfg.glyph_count) ? mapped : '0;
   end

   always_ff @(posedge clock) begin
      s2_idx_ff  <= s2_idx_in;
      s2_prod_ff <= PROD_W'(s2_idx_in) * PROD_W'(cfg.bytes_per_glyph);
   end

   assign rq_pop      = pop && !empty;
   assign rq_count_in = rq_count_ff + RQ_CNT_W'(s2_valid_ff) - RQ_CNT_W'(rq_pop);

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         rq_idx_ff[rq_wr_ff] <= s2_idx_ff;
         rq_off_ff[rq_wr_ff] <= OFFSET_W'(PROD_W'(cfg.header_size) + s2_prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= lookup_go;
         s2_valid_ff <= s1_valid_ff;
         rq_wr_ff    <= rq_wr_ff + RQ_PTR_W'(s2_valid_ff);
         rq_rd_ff    <= rq_rd_ff + RQ_PTR_W'(rq_pop);
         rq_count_ff <= rq_count_in;
      end
   end

   assign empty            = (rq_count_ff == '0);
   assign rsp_glyph_index  = rq_idx_ff[rq_rd_ff];
   assign rsp_glyph_offset = rq_off_ff[rq_rd_ff];

   a_no_op_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !op_pop)
      else $error("map access during clear");
   a_rq_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (rq_count_ff < RQ_CNT_W'(RQ_DEPTH)) || rq_pop)
      else $error("result queue overrun");
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      clr_ff && clr_addr_ff == CODE_BITS'(MAP_DEPTH - 1) |=> !clr_ff)
      else $error("clear sweep did not finish");
   a_rq_bound: assert property (@(posedge clock) disable iff (reset)
      committed <= RQ_CNT_W'(RQ_DEPTH))
      else $error("result slots overcommitted");

endmodule

// File: rtl/psf_unicode_glyph_map_top.sv
// Glyph map built from a PSF2 font's unicode table, with glyph lookup.
//
// Request channel (push/full): req_action 0 feeds one table byte, decoded
// as UTF-8; 0xFF advances the glyph counter, each complete code point gets
// the current glyph number in a 64K-entry map. req_action 1 looks up
// req_codepoint and produces one response; fed bytes produce none.
// Response channel (empty/pop): rsp_glyph_index is the mapped glyph
// (0 when out of range of glyph_count), rsp_glyph_offset its byte offset.
// CSR channel (csr_valid/csr_ready) is always ready; write only when idle.
// Throughput: one request per cycle while full is low, set by the single map memory port.
// A lookup reaches the response side through the request queue, the map
// read, clamp and multiply, and the add into the response queue.
// Reset: the map is cleared by a sweep over all 65536 entries, one entry per
// cycle; full stays high for the whole sweep. CSR writes work throughout.
// Receiver stall: responses back up in a 4-entry queue; lookups wait in
// the 4-entry request queue, and full rises when that fills.
module psf_unicode_glyph_map_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_action,
   input  logic [7:0]                          req_table_byte,
   input  logic [15:0]                         req_codepoint,
   output logic                                empty,
   input  logic                                pop,
   output logic [pugm_pkg::GLYPH_W-1:0]        rsp_glyph_index,
   output logic [pugm_pkg::OFFSET_W-1:0]       rsp_glyph_offset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pugm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pugm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pugm_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   stat_type stat;
   op_type   op;
   logic     op_valid;
   logic     op_pop;

   // CSR writes are registered straight into cfg_ff, so the port never stalls
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TABLE_PRESENT:   cfg_in.table_present   = csr_wdata[0];
            CSR_GLYPH_COUNT:     cfg_in.glyph_count     = csr_wdata[GLYPH_W-1:0];
            CSR_HEADER_SIZE:     cfg_in.header_size     = csr_wdata[HDR_W-1:0];
            CSR_BYTES_PER_GLYPH: cfg_in.bytes_per_glyph = csr_wdata[BPG_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_present   <= 1'b0;
         cfg_ff.glyph_count     <= '0;
         cfg_ff.header_size     <= HEADER_SIZE_RST;
         cfg_ff.bytes_per_glyph <= BYTES_PER_GLYPH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and decode requests into map writes and lookups
   pugm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_action     (req_action),
      .req_table_byte (req_table_byte),
      .req_codepoint  (req_codepoint),
      .stat           (stat),
      .op_valid       (op_valid),
      .op             (op),
      .op_pop         (op_pop)
   );

   // back: map memory, clear sweep, lookup pipeline, response queue
   pugm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .stat             (stat),
      .op_valid         (op_valid),
      .op               (op),
      .op_pop           (op_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_glyph_index  (rsp_glyph_index),
      .rsp_glyph_offset (rsp_glyph_offset)
   );

endmodule

// File: bench/tb_psf_unicode_glyph_map_top.sv
`timescale 1ns / 1ps

module tb_psf_unicode_glyph_map_top;
   import pugm_pkg::*;

   // Bench timing knobs
   localparam int RESET_CYCLES = 12;
   localparam int SETTLE_CYCLES = 8;       // past the lookup pipeline
   localparam int CYCLE_LIMIT = 1000000;   // map clear + traffic, many times over
   localparam int MAX_REPORTS = 10;
   localparam int RECENT_DEPTH = 32;

   typedef struct packed {
      logic [GLYPH_W-1:0]  index;
      logic [OFFSET_W-1:0] offset;
   } glyph_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_action;
   logic [7:0]            req_table_byte;
   logic [15:0]           req_codepoint;
   logic                  empty;
   logic                  pop;
   logic [GLYPH_W-1:0]    rsp_glyph_index;
   logic [OFFSET_W-1:0]   rsp_glyph_offset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   psf_unicode_glyph_map_top dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_table_byte   (req_table_byte),
      .req_codepoint    (req_codepoint),
      .empty            (empty),
      .pop              (pop),
      .rsp_glyph_index  (rsp_glyph_index),
      .rsp_glyph_offset (rsp_glyph_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Shadow of the block: glyph map, decoder state and CSRs
   // ------------------------------------------------------------------
   logic [GLYPH_W-1:0]   code_to_glyph [MAP_DEPTH];
   logic [GLYPH_W-1:0]   glyph_num;      // glyph that new code points go to
   logic [1:0]           cont_left;      // continuation bytes still owed
   logic [CODE_BITS-1:0] code_accum;     // code point built so far
   cfg_type              cfg_shadow;

   glyph_rsp_type pending_glyphs [$];    // lookups accepted, response not yet seen
   logic [15:0]   recent_codes [$];      // code points written lately, for hits

   int tx_idle_pct;
   int rx_idle_pct;
   int mismatch_count = 0;
   int cycle_count = 0;
   glyph_rsp_type want;

   // One table byte into the shadow decoder.
   function automatic void decode_table_byte(input logic [7:0] b);
      if (cont_left != 2'd0) begin
         // Every byte counts as a continuation here, 0xFF included
         code_accum = {code_accum[CODE_BITS-7:0], b[5:0]};
         cont_left  = cont_left - 2'd1;
         if (cont_left == 2'd0)
            code_to_glyph[code_accum] = glyph_num;
      end else if (b == BYTE_GLYPH_END) begin
         glyph_num = glyph_num + 1'b1;
      end else if (!b[7]) begin
         code_to_glyph[CODE_BITS'(b)] = glyph_num;
      end else if (!b[5]) begin
         // also catches a stray continuation byte 0x80..0x9F seen as a lead
         code_accum = CODE_BITS'(b[4:0]);
         cont_left  = 2'd1;
      end else if (!b[4]) begin
         code_accum = CODE_BITS'(b[3:0]);
         cont_left  = 2'd2;
      end else if (!b[3]) begin
         code_accum = CODE_BITS'(b[2:0]);
         cont_left  = 2'd3;
      end else begin
         // invalid lead: code point 0 right away
         code_to_glyph[0] = glyph_num;
      end
   endfunction

   // Glyph index and bitmap offset for one lookup.
   function automatic glyph_rsp_type lookup_glyph(input logic [15:0] cp);
      logic [GLYPH_W-1:0] g;
      glyph_rsp_type      r;
      g = cfg_shadow.table_present ? code_to_glyph[cp[CODE_BITS-1:0]] : cp;
      if (g == '0 || g >= cfg_shadow.glyph_count)
         g = '0;
      r.index  = g;
      r.offset = OFFSET_W'(cfg_shadow.header_size)
               + OFFSET_W'(g) * OFFSET_W'(cfg_shadow.bytes_per_glyph);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Clock, watchdog, response side
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_glyphs.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: drops pop at random per the current idle rate
   always @(posedge clock) begin
      if (reset)
         pop <= 1'b0;
      else
         pop <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Response checker: values seen here are those before the edge
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_glyphs.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected response: index %0d offset %0d",
                        rsp_glyph_index, rsp_glyph_offset);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = pending_glyphs.pop_front();
            if (rsp_glyph_index !== want.index || rsp_glyph_offset !== want.offset) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("glyph mismatch: expected index %0d offset %0d, got index %0d offset %0d",
                           want.index, want.offset, rsp_glyph_index, rsp_glyph_offset);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Holds push high once raised; only an idle cycle or settle() lowers it, so push
   // never sees two updates in one step.
   task automatic push_request(input logic act, input logic [7:0] b, input logic [15:0] cp);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_action     <= act;
      req_table_byte <= b;
      req_codepoint  <= cp;
      @(posedge clock);
      while (full)
         @(posedge clock);
      // accepted at this edge
      if (act == ACTION_LOOKUP)
         pending_glyphs.push_back(lookup_glyph(cp));
      else
         decode_table_byte(b);
   endtask

   // unused field carries random junk
   task automatic feed_table_byte(input logic [7:0] b);
      push_request(ACTION_FEED, b, 16'($urandom));
   endtask

   task automatic request_lookup(input logic [15:0] cp);
      push_request(ACTION_LOOKUP, 8'($urandom), cp);
   endtask

   // Stop sending, drain every response, then let fed bytes finish.
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_glyphs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TABLE_PRESENT:   cfg_shadow.table_present   = data[0];
         CSR_GLYPH_COUNT:     cfg_shadow.glyph_count     = data[GLYPH_W-1:0];
         CSR_HEADER_SIZE:     cfg_shadow.header_size     = data[HDR_W-1:0];
         CSR_BYTES_PER_GLYPH: cfg_shadow.bytes_per_glyph = data[BPG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic tp, input logic [15:0] count,
                             input logic [15:0] hdr, input logic [15:0] bpg);
      write_csr(CSR_TABLE_PRESENT, {15'd0, tp});
      write_csr(CSR_GLYPH_COUNT, count);
      write_csr(CSR_HEADER_SIZE, hdr);
      write_csr(CSR_BYTES_PER_GLYPH, bpg);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Reset config (no table, zero glyphs) first, then pass-through with
   // clamping at both ends of the code range.
   task automatic test_passthrough();
      request_lookup(16'h0041);
      request_lookup(16'hFFFF);
      settle();
      set_config(1'b0, 16'd100, 16'hFFFF, 16'd4096);
      request_lookup(16'h0000);
      request_lookup(16'h0001);
      request_lookup(16'd99);
      request_lookup(16'd100);
      request_lookup(16'hFFFF);
      settle();
   endtask

   // One sequence of each length, 0xFF as a continuation, an invalid
   // lead, a stray continuation, and a lookup in the middle of a sequence.
   task automatic test_utf8_decode();
      set_config(1'b1, 16'hFFFF, 16'h0000, 16'd1);
      feed_table_byte(8'h41);                 // ASCII, glyph 0
      feed_table_byte(BYTE_GLYPH_END);
      feed_table_byte(8'hC3);                 // two bytes, glyph 1
      feed_table_byte(8'hA9);
      feed_table_byte(BYTE_GLYPH_END);
      feed_table_byte(8'hE2);                 // three bytes, glyph 2
      feed_table_byte(8'h82);
      feed_table_byte(8'hAC);
      feed_table_byte(BYTE_GLYPH_END);
      feed_table_byte(8'hF0);                 // four bytes, truncated
      request_lookup(16'h20AC);               // must not upset the sequence
      feed_table_byte(8'h9F);
      feed_table_byte(8'h98);
      feed_table_byte(BYTE_GLYPH_END);        // taken as last continuation
      feed_table_byte(8'hF8);                 // invalid lead -> code 0
      feed_table_byte(8'h80);                 // stray continuation as lead
      feed_table_byte(8'h41);
      request_lookup(16'h00E9);
      request_lookup(16'hF63F);
      request_lookup(16'h0000);
      request_lookup(16'h0001);
      settle();
   endtask

   // Largest offset through pass-through, then the glyph_count edge in
   // table mode around the current glyph counter.
   task automatic test_glyph_limits();
      logic [GLYPH_W-1:0] last_glyph;
      set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'd4096);
      request_lookup(16'hFFFE);               // largest offset
      request_lookup(16'hFFFF);               // at glyph_count -> 0
      settle();
      last_glyph = glyph_num;
      set_config(1'b1, last_glyph + 16'd1, 16'hFFFF, 16'd4096);
      feed_table_byte(8'h5A);                 // last glyph in range
      feed_table_byte(BYTE_GLYPH_END);
      feed_table_byte(8'h5B);                 // one past the last glyph
      request_lookup(16'h005A);
      request_lookup(16'h005B);
      settle();
   endtask

   // Mostly well-formed UTF-8 with glyph breaks, lookups aimed at codes
   // written lately, and some raw noise that breaks sequences.
   task automatic random_traffic(input int n_items);
      int          sent;
      int          roll;
      int          len;
      logic [20:0] ucode;
      logic [7:0]  seq [4];
      sent = 0;
      while (sent < n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            if (recent_codes.size() != 0 && $urandom_range(0, 3) != 0)
               request_lookup(recent_codes[$urandom_range(0, recent_codes.size() - 1)]);
            else
               request_lookup(16'($urandom));
            sent++;
         end else if (roll < 45) begin
            feed_table_byte(8'($urandom_range(0, 255)));
            sent++;
         end else begin
            len = $urandom_range(1, 4);
            case (len)
               1: begin
                  ucode  = 21'($urandom_range(0, 'h7F));
                  seq[0] = ucode[7:0];
               end
               2: begin
                  ucode  = 21'($urandom_range('h80, 'h7FF));
                  seq[0] = {3'b110, ucode[10:6]};
                  seq[1] = {2'b10, ucode[5:0]};
               end
               3: begin
                  ucode  = 21'($urandom_range('h800, 'hFFFF));
                  seq[0] = {4'b1110, ucode[15:12]};
                  seq[1] = {2'b10, ucode[11:6]};
                  seq[2] = {2'b10, ucode[5:0]};
               end
               default: begin
                  ucode  = 21'($urandom_range('h10000, 'h10FFFF));
                  seq[0] = {5'b11110, ucode[20:18]};
                  seq[1] = {2'b10, ucode[17:12]};
                  seq[2] = {2'b10, ucode[11:6]};
                  seq[3] = {2'b10, ucode[5:0]};
               end
            endcase
            for (int k = 0; k < len; k++)
               feed_table_byte(seq[k]);
            sent += len;
            recent_codes.push_back(ucode[15:0]);
            if (recent_codes.size() > RECENT_DEPTH)
               void'(recent_codes.pop_front());
            if ($urandom_range(0, 2) == 0) begin
               feed_table_byte(BYTE_GLYPH_END);
               sent++;
            end
         end
      end
      settle();
   endtask

   task automatic test_random_phase(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      set_config(1'b1, 16'($urandom_range(2, 40)), 16'($urandom), 16'($urandom_range(0, 4096)));
      random_traffic(100);
      set_config(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 4096)));
      random_traffic(100);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      push           <= 1'b0;
      req_action     <= ACTION_FEED;
      req_table_byte <= 8'h00;
      req_codepoint  <= 16'h0000;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_TABLE_PRESENT;
      csr_wdata      <= '0;

      for (int i = 0; i < MAP_DEPTH; i++)
         code_to_glyph[i] = '0;
      glyph_num  = '0;
      cont_left  = 2'd0;
      code_accum = '0;
      cfg_shadow = '{table_present: 1'b0, glyph_count: '0,
                     header_size: HEADER_SIZE_RST, bytes_per_glyph: BYTES_PER_GLYPH_RST};

      // sender mostly busy, receiver mostly stalled
      tx_idle_pct = 7;
      rx_idle_pct = 72;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // requests wait out the map clear behind full
      test_passthrough();
      test_utf8_decode();
      test_random_phase(7, 72);
      test_random_phase(72, 7);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_glyph_limits();
      test_random_phase(0, 0);
      // extremes of the small end: one glyph, zero-size bitmaps
      set_config(1'b1, 16'd1, 16'h0000, 16'd0);
      random_traffic(40);

      if (mismatch_count == 0 && pending_glyphs.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
